// File: src/mtkc_pkg.sv
// Shared types, constants and the output tempering function for the MT19937
// keystream byte cipher. No dependencies; imported by every file but mtkc_ram.
package mtkc_pkg;

	localparam int unsigned STATE_WORDS  = 624;
	localparam int unsigned TWIST_OFFSET = 397;
	localparam int unsigned ADDR_W       = $clog2(STATE_WORDS);
	localparam int unsigned WORD_W       = 32;

	localparam logic [WORD_W-1:0] MT_INIT_MULT = 32'h6C07_8965;
	localparam logic [WORD_W-1:0] MT_MATRIX    = 32'h9908_B0DF;
	localparam logic [WORD_W-1:0] MT_TEMPER_B  = 32'h9D2C_5680;
	localparam logic [WORD_W-1:0] MT_TEMPER_C  = 32'hEFC6_0000;

	localparam logic [7:0] KEY_RESET  = 8'hC5;
	localparam logic [7:0] STEP_RESET = 8'h83;
	localparam logic [7:0] STEP_INC   = 8'h53;

	// Controller states, one-hot.
	typedef enum logic [7:0] {
		ST_INIT0 = 8'b0000_0001,
		ST_MUL   = 8'b0000_0010,
		ST_WR    = 8'b0000_0100,
		ST_IDLE  = 8'b0000_1000,
		ST_RDA   = 8'b0001_0000,
		ST_RDB   = 8'b0010_0000,
		ST_GEN   = 8'b0100_0000,
		ST_EMIT  = 8'b1000_0000
	} mtkc_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic seed_load;
		logic init_first;
		logic init_mul;
		logic init_wr;
		logic item_take;
		logic latch_a;
		logic latch_b;
		logic gen_word;
		logic emit;
	} mtkc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic init_done;
		logic out_free;
	} mtkc_status_t;

	function automatic logic [WORD_W-1:0] mt_temper(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & MT_TEMPER_B);
		y = y ^ ((y << 15) & MT_TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

// File: src/mtkc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Holds the generator state words; no package dependencies.
module mtkc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 624
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/mtkc_ctrl.sv
// Controller state machine: sequences the table fill after a seed load and
// the read, regenerate and emit steps of each byte. Depends on mtkc_pkg.
module mtkc_ctrl import mtkc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         cfg_valid,
	input  mtkc_status_t status,
	output mtkc_cmd_t    cmd
);

	mtkc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT0;
		end else begin
			state_q <= state_d;
		end
	end

	// A seed write takes priority, so no byte is taken at the same edge.
	assign in_ready = (state_q == ST_IDLE) && !cfg_valid;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		unique case (state_q)
			ST_INIT0: begin
				cmd.init_first = 1'b1;
				state_d        = ST_MUL;
			end
			ST_MUL: begin
				cmd.init_mul = 1'b1;
				state_d      = ST_WR;
			end
			ST_WR: begin
				cmd.init_wr = 1'b1;
				state_d     = status.init_done ? ST_IDLE : ST_MUL;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.item_take = 1'b1;
					state_d       = ST_RDA;
				end
			end
			ST_RDA: begin
				cmd.latch_a = 1'b1;
				state_d     = ST_RDB;
			end
			ST_RDB: begin
				cmd.latch_b = 1'b1;
				state_d     = ST_GEN;
			end
			ST_GEN: begin
				cmd.gen_word = 1'b1;
				state_d      = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT0;
			end
		endcase
		// A new seed restarts the table fill from any state.
		if (cfg_valid) begin
			cmd           = '0;
			cmd.seed_load = 1'b1;
			state_d       = ST_INIT0;
		end
	end

endmodule

// File: src/mtkc_dp.sv
// Datapath: seed register, state table RAM, fill multiplier, on-the-fly
// twist, tempering, running key and the output register. Depends on mtkc_pkg, mtkc_ram.
module mtkc_dp import mtkc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mtkc_cmd_t         cmd,
	output mtkc_status_t      status,
	input  logic [WORD_W-1:0] seed,
	input  logic [7:0]        data_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        data_out
);

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_WORDS - 1);
	localparam logic [ADDR_W-1:0] WRAP_LIM  = ADDR_W'(STATE_WORDS - TWIST_OFFSET);
	localparam logic [ADDR_W-1:0] FAR_ADD   = ADDR_W'(TWIST_OFFSET);

	logic [WORD_W-1:0] seed_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [ADDR_W-1:0] idx_q;
	logic [7:0]        key_q;
	logic [7:0]        step_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] prev_q;
	logic [WORD_W-1:0] prod_q;
	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] b_q;
	logic [WORD_W-1:0] word_q;
	logic [7:0]        din_q;
	logic [7:0]        data_out_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	logic [ADDR_W-1:0] ptr_next;
	logic [ADDR_W-1:0] ptr_far;
	logic [WORD_W-1:0] init_word;
	logic [WORD_W-1:0] twist_y;
	logic [WORD_W-1:0] twist_word;
	logic [WORD_W-1:0] tempered;

	assign ptr_next   = (ptr_q == LAST_ADDR) ? '0 : ptr_q + ADDR_W'(1);
	assign ptr_far    = (ptr_q < WRAP_LIM) ? ptr_q + FAR_ADD : ptr_q - WRAP_LIM;
	assign init_word  = prod_q + WORD_W'(idx_q);
	assign twist_y    = {a_q[WORD_W-1], b_q[WORD_W-2:0]};
	assign twist_word = ram_rdata ^ (twist_y >> 1) ^ (twist_y[0] ? MT_MATRIX : '0);
	assign tempered   = mt_temper(word_q);

	// Regenerating word p in place while drawing it matches a full-table
	// twist, since words below p are already new and the rest still old.
	always_comb begin
		ram_we    = cmd.init_first | cmd.init_wr | cmd.gen_word;
		ram_waddr = ptr_q;
		ram_wdata = twist_word;
		if (cmd.init_first) begin
			ram_waddr = '0;
			ram_wdata = seed_q;
		end else if (cmd.init_wr) begin
			ram_waddr = idx_q;
			ram_wdata = init_word;
		end
		if (cmd.latch_a) begin
			ram_raddr = ptr_next;
		end else if (cmd.latch_b) begin
			ram_raddr = ptr_far;
		end else begin
			ram_raddr = ptr_q;
		end
	end

	mtkc_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STATE_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= '0;
			ptr_q       <= '0;
			idx_q       <= '0;
			key_q       <= KEY_RESET;
			step_q      <= STEP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.seed_load) begin
				seed_q <= seed;
				ptr_q  <= '0;
				key_q  <= KEY_RESET;
				step_q <= STEP_RESET;
			end
			if (cmd.init_first) begin
				idx_q <= ADDR_W'(1);
			end else if (cmd.init_wr) begin
				idx_q <= idx_q + ADDR_W'(1);
			end
			if (cmd.gen_word) begin
				ptr_q <= ptr_next;
			end
			if (cmd.emit) begin
				key_q       <= key_q + step_q;
				step_q      <= step_q + STEP_INC;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init_first) begin
			prev_q <= seed_q;
		end else if (cmd.init_wr) begin
			prev_q <= init_word;
		end
		if (cmd.init_mul) begin
			prod_q <= WORD_W'(MT_INIT_MULT * (prev_q ^ (prev_q >> 30)));
		end
		if (cmd.item_take) begin
			din_q <= data_in;
		end
		if (cmd.latch_a) begin
			a_q <= ram_rdata;
		end
		if (cmd.latch_b) begin
			b_q <= ram_rdata;
		end
		if (cmd.gen_word) begin
			word_q <= twist_word;
		end
		if (cmd.emit) begin
			data_out_q <= din_q ^ tempered[7:0] ^ key_q;
		end
	end

	assign status.init_done = (idx_q == LAST_ADDR);
	assign status.out_free  = !out_valid_q || out_ready;
	assign out_valid        = out_valid_q;
	assign data_out         = data_out_q;

endmodule

// File: src/mt19937_keystream_byte_cipher.sv
// Top level of the MT19937 keystream byte cipher: joins the controller and
// the datapath. Depends on mtkc_pkg, mtkc_ctrl, mtkc_dp (and through it mtkc_ram).
//
//   Channel  Handshake              Payload
//   input    in_valid / in_ready    data_in  [7:0]
//   output   out_valid / out_ready  data_out [7:0]
//   config   cfg_valid / cfg_ready  seed     [31:0]
//
// After reset or a seed write the state table is filled word by word
// (multiply, then add and write), with in_ready low.
// A byte passes through three reads of the single-read-port table RAM, then
// regenerate, then temper and load; the next byte is not taken before the
// result of the last one is loaded.
// A result waiting on out_ready holds the next byte in its last step and so
// keeps in_ready low; cfg_ready is always high and a seed write lowers in_ready.
module mt19937_keystream_byte_cipher import mtkc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        data_out,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [WORD_W-1:0] seed
);

	mtkc_cmd_t    cmd;
	mtkc_status_t status;

	assign cfg_ready = 1'b1;

	mtkc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cfg_valid(cfg_valid),
		.status   (status),
		.cmd      (cmd)
	);

	mtkc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.seed     (seed),
		.data_in  (data_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.data_out (data_out)
	);

endmodule
